// ----- design/rrm_pkg.sv -----
// Shared constants, types and helper functions for the relative rotation block.
// No dependencies; rrm_if.sv and relative_rotation_matrix.sv refer to this package by scoped names.
package rrm_pkg;

  localparam int EW     = 16;              // matrix element width
  localparam int FRAC   = EW - 2;          // fraction bits (Q2.14 at 16 bits)
  localparam int ADJ_W  = 2 * EW + 1;      // cofactor width
  localparam int PROD_W = EW + ADJ_W;      // shared multiplier output width
  localparam int ACC_W  = PROD_W + 1;      // accumulator width
  localparam int DIV_W  = 4 * EW;          // divider remainder width
  localparam int CNT_W  = $clog2(EW);      // quotient bit counter width

  localparam logic CMD_RENDER  = 1'b0;
  localparam logic CMD_CAPTURE = 1'b1;

  localparam logic [1:0] SRC_LAT = 2'd0;
  localparam logic [1:0] SRC_ADJ = 2'd1;
  localparam logic [1:0] SRC_REF = 2'd2;

  localparam logic [4:0] T_DET_FIRST = 5'd18;
  localparam logic [4:0] T_DET_LAST  = 5'd20;

  localparam logic signed [EW-1:0] ONE      = EW'(1) << FRAC;
  localparam logic signed [EW-1:0] ELEM_MAX = {1'b0, {(EW-1){1'b1}}};
  localparam logic signed [EW-1:0] ELEM_MIN = {1'b1, {(EW-1){1'b0}}};

  typedef logic signed [EW-1:0] elem_t;

  typedef struct packed {
    logic [3:0] a_idx;
    logic [1:0] b_src;
    logic [3:0] b_idx;
    logic       first;
    logic       sub;
    logic       last;
  } term_t;

  function automatic elem_t identity_elem(input int idx);
    return (idx % 4 == 0) ? ONE : '0;
  endfunction

  // Capture sequence: nine cofactors (two terms each), then the determinant.
  function automatic term_t cap_term(input logic [4:0] t);
    term_t r;
    logic [3:0] a;
    logic [3:0] b;
    a = 4'd0;
    b = 4'd0;
    unique case (t)
      5'd0:  begin a = 4'd4; b = 4'd8; end
      5'd1:  begin a = 4'd5; b = 4'd7; end
      5'd2:  begin a = 4'd2; b = 4'd7; end
      5'd3:  begin a = 4'd1; b = 4'd8; end
      5'd4:  begin a = 4'd1; b = 4'd5; end
      5'd5:  begin a = 4'd2; b = 4'd4; end
      5'd6:  begin a = 4'd5; b = 4'd6; end
      5'd7:  begin a = 4'd3; b = 4'd8; end
      5'd8:  begin a = 4'd0; b = 4'd8; end
      5'd9:  begin a = 4'd2; b = 4'd6; end
      5'd10: begin a = 4'd2; b = 4'd3; end
      5'd11: begin a = 4'd0; b = 4'd5; end
      5'd12: begin a = 4'd3; b = 4'd7; end
      5'd13: begin a = 4'd4; b = 4'd6; end
      5'd14: begin a = 4'd1; b = 4'd6; end
      5'd15: begin a = 4'd0; b = 4'd7; end
      5'd16: begin a = 4'd0; b = 4'd4; end
      5'd17: begin a = 4'd1; b = 4'd3; end
      5'd18: begin a = 4'd0; b = 4'd0; end
      5'd19: begin a = 4'd1; b = 4'd3; end
      5'd20: begin a = 4'd2; b = 4'd6; end
      default: begin a = 4'd0; b = 4'd0; end
    endcase
    r.a_idx = a;
    r.b_idx = b;
    if (t < T_DET_FIRST) begin
      r.b_src = SRC_LAT;
      r.first = ~t[0];
      r.sub   = t[0];
      r.last  = t[0];
    end else begin
      r.b_src = SRC_ADJ;
      r.first = (t == T_DET_FIRST);
      r.sub   = 1'b0;
      r.last  = (t == T_DET_LAST);
    end
    return r;
  endfunction

  // Add half an LSB, floor, saturate.
  function automatic elem_t round_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] s;
    logic signed [ACC_W-1:0] sh;
    s  = v + (ACC_W'(1) << (FRAC - 1));
    sh = s >>> FRAC;
    if (sh > ACC_W'(ELEM_MAX)) return ELEM_MAX;
    if (sh < ACC_W'(ELEM_MIN)) return ELEM_MIN;
    return sh[EW-1:0];
  endfunction

endpackage

// ----- design/rrm_if.sv -----
// Valid/ready channel interfaces for the matrix input and the product output.
// Depends on rrm_pkg for the element type.
interface rrm_in_if;
  logic            valid;
  logic            ready;
  logic            command;
  rrm_pkg::elem_t  m11, m12, m13, m21, m22, m23, m31, m32, m33;
  modport source(output valid, command, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                 input ready);
  modport sink(input valid, command, m11, m12, m13, m21, m22, m23, m31, m32, m33,
               output ready);
endinterface

interface rrm_out_if;
  logic            valid;
  logic            ready;
  rrm_pkg::elem_t  c11, c12, c13, c21, c22, c23, c31, c32, c33;
  logic            reference_invalid;
  modport source(output valid, c11, c12, c13, c21, c22, c23, c31, c32, c33,
                 reference_invalid, input ready);
  modport sink(input valid, c11, c12, c13, c21, c22, c23, c31, c32, c33,
               reference_invalid, output ready);
endinterface

// ----- design/relative_rotation_matrix.sv -----
// Relative rotation: product of the latest matrix with a captured reference inverse.
// Depends on rrm_pkg and the channel interfaces in rrm_if.sv.
//
//  channel  dir  payload                          transfer when
//  in_ch    in   command, m11..m33                valid & ready
//  out_ch   out  c11..c33, reference_invalid      valid & ready
//
// One shared multiplier (element x element or cofactor) feeds an accumulator,
// alternating multiply and add cycles. A render computes 27 terms, then loads
// and hands off the result; a capture computes 21 cofactor and determinant terms,
// then nine divisions on a one-bit-per-cycle divider (none if singular).
// rst clears the state to identity; in_ch.ready is high only while idle; a stalled
// output holds, and the block can take the next item while it waits.
module relative_rotation_matrix (
  input logic        clk,
  input logic        rst,
  rrm_in_if.sink     in_ch,
  rrm_out_if.source  out_ch
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_MUL      = 3'd1;
  localparam logic [2:0] S_ADD      = 3'd2;
  localparam logic [2:0] S_DIV_INIT = 3'd3;
  localparam logic [2:0] S_DIV      = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  localparam int EW    = rrm_pkg::EW;
  localparam int ADJ_W = rrm_pkg::ADJ_W;
  localparam int ACC_W = rrm_pkg::ACC_W;
  localparam int DIV_W = rrm_pkg::DIV_W;

  logic [2:0]              state;
  logic                    mode_cap;
  rrm_pkg::elem_t          latest [9];
  rrm_pkg::elem_t          refm   [9];
  rrm_pkg::elem_t          res    [9];
  rrm_pkg::elem_t          oc     [9];
  logic signed [ADJ_W-1:0] adj    [9];
  logic signed [rrm_pkg::PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic [1:0]              i, j, k;
  logic [4:0]              t;
  logic [3:0]              n;
  logic [DIV_W-1:0]        det_abs;
  logic                    det_neg;
  logic [DIV_W-1:0]        rem, dsh;
  logic [EW-1:0]           q;
  logic [rrm_pkg::CNT_W-1:0] cnt;
  logic                    div_neg;
  logic                    flag;
  logic                    out_valid;
  logic                    out_inv;

  rrm_pkg::term_t          term;
  rrm_pkg::elem_t          a_op;
  logic signed [ADJ_W-1:0] b_op;
  logic signed [ACC_W-1:0] acc_next;
  logic [3:0]              res_idx;
  logic [ADJ_W-1:0]        adj_mag;
  logic                    ge;
  logic [EW-1:0]           q_next;
  rrm_pkg::elem_t          quot;
  logic                    in_fire, out_free;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE);

  always_comb begin
    if (mode_cap) begin
      term = rrm_pkg::cap_term(t);
    end else begin
      term.a_idx = {2'b00, i} * 4'd3 + {2'b00, k};
      term.b_src = rrm_pkg::SRC_REF;
      term.b_idx = {2'b00, k} * 4'd3 + {2'b00, j};
      term.first = (k == 2'd0);
      term.sub   = 1'b0;
      term.last  = (k == 2'd2);
    end
  end

  always_comb begin
    a_op = latest[term.a_idx];
    unique case (term.b_src)
      rrm_pkg::SRC_LAT: b_op = ADJ_W'(latest[term.b_idx]);
      rrm_pkg::SRC_ADJ: b_op = adj[term.b_idx];
      rrm_pkg::SRC_REF: b_op = ADJ_W'(refm[term.b_idx]);
      default:          b_op = '0;
    endcase
  end

  assign acc_next = term.sub ? ((term.first ? ACC_W'(0) : acc) - ACC_W'(prod))
                             : ((term.first ? ACC_W'(0) : acc) + ACC_W'(prod));
  assign res_idx  = {2'b00, i} * 4'd3 + {2'b00, j};

  assign adj_mag = adj[n][ADJ_W-1] ? (~adj[n] + ADJ_W'(1)) : adj[n];
  assign ge      = (rem >= dsh);
  assign q_next  = {q[EW-2:0], ge};
  always_comb begin
    if (q_next[EW-1]) begin
      quot = div_neg ? rrm_pkg::ELEM_MIN : rrm_pkg::ELEM_MAX;
    end else begin
      quot = div_neg ? -q_next : q_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mode_cap  <= 1'b0;
      flag      <= 1'b0;
      out_valid <= 1'b0;
      for (int e = 0; e < 9; e++) begin
        latest[e] <= rrm_pkg::identity_elem(e);
        refm[e]   <= rrm_pkg::identity_elem(e);
      end
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            mode_cap <= (in_ch.command == rrm_pkg::CMD_CAPTURE);
            i <= 2'd0;
            j <= 2'd0;
            k <= 2'd0;
            t <= 5'd0;
            state <= S_MUL;
            if (in_ch.command == rrm_pkg::CMD_RENDER) begin
              latest[0] <= in_ch.m11; latest[1] <= in_ch.m12; latest[2] <= in_ch.m13;
              latest[3] <= in_ch.m21; latest[4] <= in_ch.m22; latest[5] <= in_ch.m23;
              latest[6] <= in_ch.m31; latest[7] <= in_ch.m32; latest[8] <= in_ch.m33;
            end
          end
        end
        S_MUL: begin
          prod  <= rrm_pkg::PROD_W'(a_op) * rrm_pkg::PROD_W'(b_op);
          state <= S_ADD;
        end
        S_ADD: begin
          acc <= acc_next;
          if (mode_cap) begin
            t <= t + 5'd1;
            if (term.last && t < rrm_pkg::T_DET_FIRST) begin
              adj[t[4:1]] <= acc_next[ADJ_W-1:0];
            end
            if (t == rrm_pkg::T_DET_LAST) begin
              if (acc_next == '0) begin
                flag  <= 1'b1;
                state <= S_IDLE;
              end else begin
                det_neg <= acc_next[ACC_W-1];
                det_abs <= DIV_W'(acc_next[ACC_W-1] ? -acc_next : acc_next);
                n       <= 4'd0;
                state   <= S_DIV_INIT;
              end
            end else begin
              state <= S_MUL;
            end
          end else begin
            if (term.last) begin
              res[res_idx] <= rrm_pkg::round_sat(acc_next);
              k <= 2'd0;
              if (j == 2'd2) begin
                j     <= 2'd0;
                i     <= i + 2'd1;
                state <= (i == 2'd2) ? S_DONE : S_MUL;
              end else begin
                j     <= j + 2'd1;
                state <= S_MUL;
              end
            end else begin
              k     <= k + 2'd1;
              state <= S_MUL;
            end
          end
        end
        S_DIV_INIT: begin
          rem     <= (DIV_W'(adj_mag) << (2 * rrm_pkg::FRAC)) + (det_abs >> 1);
          dsh     <= det_abs << (EW - 1);
          q       <= '0;
          cnt     <= rrm_pkg::CNT_W'(EW - 1);
          div_neg <= adj[n][ADJ_W-1] ^ det_neg;
          state   <= S_DIV;
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle; top bit means saturate
          if (ge) begin
            rem <= rem - dsh;
          end
          q   <= q_next;
          dsh <= dsh >> 1;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            refm[n] <= quot;
            n       <= n + 4'd1;
            state   <= (n == 4'd8) ? S_IDLE : S_DIV_INIT;
          end
        end
        S_DONE: begin
          if (out_free) begin
            for (int e = 0; e < 9; e++) begin
              oc[e] <= res[e];
            end
            out_inv <= flag;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.c11 = oc[0];
  assign out_ch.c12 = oc[1];
  assign out_ch.c13 = oc[2];
  assign out_ch.c21 = oc[3];
  assign out_ch.c22 = oc[4];
  assign out_ch.c23 = oc[5];
  assign out_ch.c31 = oc[6];
  assign out_ch.c32 = oc[7];
  assign out_ch.c33 = oc[8];
  assign out_ch.reference_invalid = out_inv;

endmodule

// ----- design/rrm_checker.sv -----
// Port-level checks for relative_rotation_matrix, attached with a bind.
// Depends only on the top level's clock, reset and channel signals.
module rrm_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_inv
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output dropped before transfer");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready after accepting an item");

  a_invalid_sticky: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_inv) |=> (!out_valid || out_inv))
    else $error("invalid flag cleared");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind relative_rotation_matrix rrm_checker u_rrm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_inv   (out_ch.reference_invalid)
);
